@@ rtl/core/adrf_pkg.sv @@
package adrf_pkg;

    // Packet geometry
    localparam int unsigned SIG_LEN      = 7;
    localparam logic [9:0]  POS_MAX      = 10'd1023;
    localparam logic [9:0]  POS_OPC_LO   = 10'd8;
    localparam logic [9:0]  POS_OPC_HI   = 10'd9;
    localparam logic [9:0]  POS_SEQ      = 10'd12;
    localparam logic [9:0]  POS_UNI_LO   = 10'd14;
    localparam logic [9:0]  POS_UNI_HI   = 10'd15;
    localparam logic [9:0]  DMX_OFFSET   = 10'd18;
    localparam logic [9:0]  POS_MIN_LAST = 10'd17;
    localparam logic [15:0] LEN_MIN_EXCL = 16'd17;
    localparam logic [15:0] LEN_MAX      = 16'd530;
    localparam logic [10:0] UNI_SLOTS    = 11'd512;

    // Opcodes
    localparam logic [15:0] OPC_DMX  = 16'h5000;
    localparam logic [15:0] OPC_POLL = 16'h2000;

    // Packet kind codes
    localparam logic [2:0] KIND_REJECT    = 3'd0;
    localparam logic [2:0] KIND_DMX_USED  = 3'd1;
    localparam logic [2:0] KIND_DMX_OTHER = 3'd2;
    localparam logic [2:0] KIND_POLL      = 3'd3;
    localparam logic [2:0] KIND_OTHER     = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_FIRST_UNI = 2'd0;
    localparam logic [1:0] REG_START_CH  = 2'd1;
    localparam logic [1:0] REG_TOTAL_CH  = 2'd2;

    // Register reset values
    localparam logic [14:0] FIRST_UNI_RST = 15'd0;
    localparam logic [8:0]  START_CH_RST  = 9'd0;
    localparam logic [10:0] TOTAL_CH_RST  = 11'd1024;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] packet_length;
        logic        last_byte;
    } t_in;

    typedef struct packed {
        logic       write_valid;
        logic [9:0] write_index;
        logic [7:0] write_value;
        logic       packet_done;
        logic [2:0] packet_kind;
        logic [7:0] sequence_number;
    } t_out;

    // Header view for the byte at hand, including that byte's own update
    typedef struct packed {
        logic [9:0]  pos;
        logic        sig_ok;
        logic [15:0] opcode;
        logic [15:0] universe;
        logic [7:0]  seq;
    } t_hdr;

    // Expected signature character at a position below SIG_LEN
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h41; // A
            3'd1:    c = 8'h72; // r
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h2D; // -
            3'd4:    c = 8'h4E; // N
            3'd5:    c = 8'h65; // e
            3'd6:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/adrf_hdr_track.sv @@
module adrf_hdr_track (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output adrf_pkg::t_hdr   o_hdr
);

    logic [9:0]  r_pos;
    logic        r_sig_ok;
    logic [15:0] r_opcode;
    logic [15:0] r_universe;
    logic [7:0]  r_seq;

    adrf_pkg::t_hdr n_hdr;

    // Fold the current byte into the header fields
    always_comb begin
        n_hdr          = '0;
        n_hdr.pos      = r_pos;
        n_hdr.sig_ok   = r_sig_ok;
        n_hdr.opcode   = r_opcode;
        n_hdr.universe = r_universe;
        n_hdr.seq      = r_seq;
        if (r_pos < 10'(adrf_pkg::SIG_LEN) &&
            i_data_byte != adrf_pkg::sig_byte(r_pos[2:0])) begin
            n_hdr.sig_ok = 1'b0;
        end
        case (r_pos)
            adrf_pkg::POS_OPC_LO: n_hdr.opcode[7:0]    = i_data_byte;
            adrf_pkg::POS_OPC_HI: n_hdr.opcode[15:8]   = i_data_byte;
            adrf_pkg::POS_SEQ:    n_hdr.seq            = i_data_byte;
            adrf_pkg::POS_UNI_LO: n_hdr.universe[7:0]  = i_data_byte;
            adrf_pkg::POS_UNI_HI: n_hdr.universe[15:8] = i_data_byte;
            default: ;
        endcase
    end

    assign o_hdr = n_hdr;

    // Per-packet state; cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sig_ok   <= 1'b1;
            r_opcode   <= '0;
            r_universe <= '0;
            r_seq      <= '0;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_pos      <= '0;
                r_sig_ok   <= 1'b1;
                r_opcode   <= '0;
                r_universe <= '0;
                r_seq      <= '0;
            end else begin
                r_sig_ok   <= n_hdr.sig_ok;
                r_opcode   <= n_hdr.opcode;
                r_universe <= n_hdr.universe;
                r_seq      <= n_hdr.seq;
                if (r_pos != adrf_pkg::POS_MAX) begin
                    r_pos <= r_pos + 10'd1;
                end
            end
        end
    end

endmodule

@@ rtl/core/adrf_slot_map.sv @@
module adrf_slot_map (
    input  adrf_pkg::t_hdr  i_hdr,
    input  logic [7:0]      i_data_byte,
    input  logic [15:0]     i_packet_length,
    input  logic            i_last_byte,
    input  logic [14:0]     i_first_universe,
    input  logic [8:0]      i_start_channel,
    input  logic [10:0]     i_total_channels,
    output adrf_pkg::t_out  o_result
);

    logic        len_ok;
    logic        is_dmx;
    logic        match1;
    logic        match2;
    logic        in_payload;
    logic [9:0]  slot;
    logic [8:0]  slot_off;
    logic        slot_sel;
    logic [10:0] second_lim;
    logic        second_ok;
    logic [2:0]  kind;

    always_comb begin
        len_ok = i_packet_length > adrf_pkg::LEN_MIN_EXCL &&
                 i_packet_length <= adrf_pkg::LEN_MAX;
        is_dmx = i_hdr.opcode == adrf_pkg::OPC_DMX;
        match1 = i_hdr.universe == {1'b0, i_first_universe};
        match2 = i_hdr.universe == ({1'b0, i_first_universe} + 16'd1);

        // Slot position and range checks
        in_payload = len_ok && i_hdr.sig_ok && is_dmx &&
                     i_hdr.pos >= adrf_pkg::DMX_OFFSET &&
                     {6'd0, i_hdr.pos} < i_packet_length;
        slot       = i_hdr.pos - adrf_pkg::DMX_OFFSET;
        slot_off   = slot[8:0] - i_start_channel;
        slot_sel   = in_payload && !slot[9] && slot[8:0] >= i_start_channel;
        second_lim = i_total_channels - adrf_pkg::UNI_SLOTS;
        second_ok  = i_total_channels > adrf_pkg::UNI_SLOTS &&
                     {1'b0, slot} < second_lim;

        // Packet classification on the last byte
        if (!len_ok || !i_hdr.sig_ok || i_hdr.pos < adrf_pkg::POS_MIN_LAST) begin
            kind = adrf_pkg::KIND_REJECT;
        end else if (is_dmx) begin
            kind = (match1 || match2) ? adrf_pkg::KIND_DMX_USED
                                      : adrf_pkg::KIND_DMX_OTHER;
        end else if (i_hdr.opcode == adrf_pkg::OPC_POLL) begin
            kind = adrf_pkg::KIND_POLL;
        end else begin
            kind = adrf_pkg::KIND_OTHER;
        end

        o_result = '0;
        if (slot_sel && match1) begin
            o_result.write_valid = 1'b1;
            o_result.write_index = {1'b0, slot_off};
            o_result.write_value = i_data_byte;
        end else if (slot_sel && match2 && second_ok) begin
            o_result.write_valid = 1'b1;
            o_result.write_index = {1'b1, slot_off};
            o_result.write_value = i_data_byte;
        end
        o_result.packet_done = i_last_byte;
        if (i_last_byte) begin
            o_result.packet_kind = kind;
            if (kind != adrf_pkg::KIND_REJECT) begin
                o_result.sequence_number = i_hdr.seq;
            end
        end
    end

endmodule

@@ rtl/core/artnet_dmx_receive_filter_core.sv @@
// Art-Net DMX receive filter, one payload byte per request.
// Each byte passes through the input register and then the result register.
// Throughput: one byte per cycle while results are taken; a result held by
// i_out_ready low stalls the pipeline. The single-pass slot mapping sets the rate.
// Reset (synchronous, active low) empties both registers, clears the packet
// state and returns the configuration registers to their defaults.
module artnet_dmx_receive_filter_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  adrf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output adrf_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [14:0]    r_first_universe;
    logic [8:0]     r_start_channel;
    logic [10:0]    r_total_channels;
    logic           r_in_valid;
    adrf_pkg::t_in  r_in;
    logic           r_out_valid;
    adrf_pkg::t_out r_out;
    logic           advance;
    logic           step;
    logic           cfg_wr;
    adrf_pkg::t_hdr hdr;
    adrf_pkg::t_out n_out;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_universe <= adrf_pkg::FIRST_UNI_RST;
            r_start_channel  <= adrf_pkg::START_CH_RST;
            r_total_channels <= adrf_pkg::TOTAL_CH_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                adrf_pkg::REG_FIRST_UNI: r_first_universe <= pwdata[14:0];
                adrf_pkg::REG_START_CH:  r_start_channel  <= pwdata[8:0];
                adrf_pkg::REG_TOTAL_CH:  r_total_channels <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            adrf_pkg::REG_FIRST_UNI: prdata = {17'd0, r_first_universe};
            adrf_pkg::REG_START_CH:  prdata = {23'd0, r_start_channel};
            adrf_pkg::REG_TOTAL_CH:  prdata = {21'd0, r_total_channels};
            default:                 prdata = '0;
        endcase
    end

    // Pipeline control: result register frees when empty or taken
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    adrf_hdr_track u_hdr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in.data_byte),
        .i_last_byte (r_in.last_byte),
        .o_hdr       (hdr)
    );

    adrf_slot_map u_map (
        .i_hdr            (hdr),
        .i_data_byte      (r_in.data_byte),
        .i_packet_length  (r_in.packet_length),
        .i_last_byte      (r_in.last_byte),
        .i_first_universe (r_first_universe),
        .i_start_channel  (r_start_channel),
        .i_total_channels (r_total_channels),
        .o_result         (n_out)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_no_kind_mid_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.packet_done |->
            o_out_data.packet_kind == adrf_pkg::KIND_REJECT &&
            o_out_data.sequence_number == 8'd0)
        else $error("packet kind or sequence set on a non-final byte");

    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_valid |->
            o_out_data.write_index == 10'd0 && o_out_data.write_value == 8'd0)
        else $error("write fields nonzero without write_valid");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.packet_kind <= adrf_pkg::KIND_OTHER)
        else $error("packet kind out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result lost or changed");

    a_pending_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while pipeline full");

endmodule
